// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the fragmenter modules
// needs clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define DFT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define DFT_ASSERT(lbl, prop)
`define DFT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/dft_pkg.sv =====
// shared types and constants for the datagram fragmenter
// no dependencies
package dft_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned ID_W    = 64;
  localparam int unsigned FRAG_W  = 32;
  localparam int unsigned CFG_W   = 16;

  localparam logic [CFG_W-1:0] PAYLOAD_RESET = 16'd1024;

  localparam int unsigned TRAILER_FIELD_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF         = 4;

  // control part of one queued request, trailer fields sit above it
  typedef struct packed {
    logic              done;
    logic              tail;
    logic [DATA_W-1:0] data;
  } cmd_ctl_t;

  localparam int unsigned CTL_W = $bits(cmd_ctl_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/dft_queue.sv =====
// small register queue between the classify front and the output back
// depends on dft_pkg and assert_macros.svh
`include "assert_macros.svh"

module dft_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  data_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  data_o,
  output dft_pkg::q_status_t stat_o
);
  import dft_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_q != CntW'(DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  `DFT_ASSERT(a_count_bound, count_q <= CntW'(DEPTH))
  `DFT_ASSERT(a_pop_drains, do_pop && !do_push |=> count_q == $past(count_q) - CntW'(1))
  `DFT_ASSERT(a_push_fills, do_push && !do_pop |=> count_q == $past(count_q) + CntW'(1))

endmodule

// ===== rtl/dft_front.sv =====
// front part: takes message bytes, tracks fragment state, queues byte requests
// depends on dft_pkg
module dft_front #(
  parameter int unsigned TRAILER_FIELD_BYTES = dft_pkg::TRAILER_FIELD_BYTES_DEF,
  parameter int unsigned CMD_W = dft_pkg::CTL_W + 24 * TRAILER_FIELD_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dft_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dft_pkg::DATA_W-1:0]  data_byte_i,
  input  logic [dft_pkg::LEN_W-1:0]   message_length_i,
  input  logic                        empty_message_i,
  input  dft_pkg::q_status_t          q_stat_i,
  output logic                        push_o,
  output logic [CMD_W-1:0]            cmd_o
);
  import dft_pkg::*;

  localparam int unsigned FieldW = 8 * TRAILER_FIELD_BYTES;

  logic [CFG_W-1:0]  payload_q;
  logic [ID_W-1:0]   msg_id_q, msg_id_d;
  logic [FRAG_W-1:0] frag_q, frag_d, frag_cur;
  logic [CFG_W-1:0]  bif_q, bif_d, bif_cur, bif_nxt, limit;
  logic [LEN_W-1:0]  left_q, left_d, left_cur;
  logic [LEN_W-1:0]  len_q, len_d, len_cur;
  logic              in_msg_q, in_msg_d;
  logic              accept, drop, done, tail;
  cmd_ctl_t          ctl;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    left_cur = in_msg_q ? left_q : message_length_i;
    len_cur  = in_msg_q ? len_q : message_length_i;
    frag_cur = in_msg_q ? frag_q : '0;
    bif_cur  = in_msg_q ? bif_q : '0;
    bif_nxt  = bif_cur + CFG_W'(1);
    limit    = (payload_q == '0) ? CFG_W'(1) : payload_q;
    done     = (left_cur == LEN_W'(1));
    tail     = (bif_nxt >= limit) || done;
    // a zero length at the start of a message counts as an empty message
    drop     = empty_message_i || (!in_msg_q && (message_length_i == '0));
  end

  always_comb begin
    msg_id_d = msg_id_q;
    frag_d   = frag_q;
    bif_d    = bif_q;
    left_d   = left_q;
    len_d    = len_q;
    in_msg_d = in_msg_q;
    if (accept) begin
      if (drop || done) begin
        in_msg_d = 1'b0;
        left_d   = '0;
        bif_d    = '0;
        frag_d   = '0;
        msg_id_d = msg_id_q + ID_W'(1);
        if (!drop) begin
          len_d = len_cur;
        end
      end else begin
        in_msg_d = 1'b1;
        len_d    = len_cur;
        left_d   = left_cur - LEN_W'(1);
        bif_d    = tail ? '0 : bif_nxt;
        frag_d   = tail ? frag_cur + FRAG_W'(1) : frag_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= PAYLOAD_RESET;
      msg_id_q  <= '0;
      frag_q    <= '0;
      bif_q     <= '0;
      left_q    <= '0;
      len_q     <= '0;
      in_msg_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        payload_q <= cfg_wdata_i;
      end
      msg_id_q <= msg_id_d;
      frag_q   <= frag_d;
      bif_q    <= bif_d;
      left_q   <= left_d;
      len_q    <= len_d;
      in_msg_q <= in_msg_d;
    end
  end

  always_comb begin
    ctl.done = done;
    ctl.tail = tail;
    ctl.data = data_byte_i;
  end

  // trailer fields: id lowest so it leaves first
  assign cmd_o  = {FieldW'(len_cur), FieldW'(frag_cur), FieldW'(msg_id_q), ctl};
  assign push_o = accept && !drop;

endmodule

// ===== rtl/dft_back.sv =====
// back part: pops byte requests, emits the byte and any trailer burst
// depends on dft_pkg and assert_macros.svh
`include "assert_macros.svh"

module dft_back #(
  parameter int unsigned TRAILER_FIELD_BYTES = dft_pkg::TRAILER_FIELD_BYTES_DEF,
  parameter int unsigned CMD_W = dft_pkg::CTL_W + 24 * TRAILER_FIELD_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dft_pkg::q_status_t          q_stat_i,
  input  logic [CMD_W-1:0]            cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dft_pkg::DATA_W-1:0]  out_byte_o,
  output logic                        fragment_last_o,
  output logic                        message_last_o
);
  import dft_pkg::*;

  localparam int unsigned TrlBytes = 3 * TRAILER_FIELD_BYTES;
  localparam int unsigned TrlW     = 8 * TrlBytes;
  localparam int unsigned CntW     = $clog2(TrlBytes + 1);

  cmd_ctl_t          ctl;
  logic [TrlW-1:0]   trl_q, trl_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              tdone_q, tdone_d;
  logic              vld_q, vld_d;
  logic [DATA_W-1:0] byte_q, byte_d;
  logic              flast_q, flast_d, mlast_q, mlast_d;
  logic              adv;

  assign ctl   = cmd_i[CTL_W-1:0];
  assign adv   = !vld_q || out_ready_i;
  assign pop_o = adv && (cnt_q == '0) && !q_stat_i.empty;

  always_comb begin
    trl_d   = trl_q;
    cnt_d   = cnt_q;
    tdone_d = tdone_q;
    vld_d   = vld_q;
    byte_d  = byte_q;
    flast_d = flast_q;
    mlast_d = mlast_q;
    if (adv) begin
      if (cnt_q != '0) begin
        vld_d   = 1'b1;
        byte_d  = trl_q[DATA_W-1:0];
        flast_d = (cnt_q == CntW'(1));
        mlast_d = (cnt_q == CntW'(1)) && tdone_q;
        trl_d   = trl_q >> DATA_W;
        cnt_d   = cnt_q - CntW'(1);
      end else if (!q_stat_i.empty) begin
        vld_d   = 1'b1;
        byte_d  = ctl.data;
        flast_d = 1'b0;
        mlast_d = 1'b0;
        if (ctl.tail) begin
          trl_d   = cmd_i[CMD_W-1:CTL_W];
          cnt_d   = CntW'(TrlBytes);
          tdone_d = ctl.done;
        end
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trl_q   <= trl_d;
    tdone_q <= tdone_d;
    byte_q  <= byte_d;
    flast_q <= flast_d;
    mlast_q <= mlast_d;
  end

  assign out_valid_o     = vld_q;
  assign out_byte_o      = byte_q;
  assign fragment_last_o = flast_q;
  assign message_last_o  = mlast_q;

  `DFT_ASSERT(a_cnt_bound, cnt_q <= CntW'(TrlBytes))
  `DFT_NEVER(a_mlast_alone, vld_q && mlast_q && !flast_q)
  `DFT_NEVER(a_flast_mid_trailer, vld_q && flast_q && (cnt_q != '0))
  `DFT_ASSERT(a_burst_starts, pop_o && ctl.tail |=> cnt_q == CntW'(TrlBytes))

endmodule

// ===== rtl/datagram_fragmenter_trailer_unit.sv =====
// Datagram fragmenter with trailer, top level.
// Input stream: one message byte per request. tdata carries the byte and the
// message length, which is taken from the first byte of each message; tuser
// marks an empty message, which produces nothing but advances the message id.
// Output stream: one byte per request, first the payload bytes, then after
// each full fragment or at message end a trailer of message id, fragment index
// and message length, each little-endian in TRAILER_FIELD_BYTES bytes.
// tlast flags the last trailer byte of a fragment, tuser the last trailer byte
// of the message.
// A byte passes the request queue and the output register. Payload moves at one
// byte per cycle while the receiver is ready; a trailer adds 3*TRAILER_FIELD_BYTES
// output bytes, during which input is taken until the QUEUE_DEPTH entry request
// queue is full. A receiver stall holds the output register and backs up through
// the queue into s_axis_tready. Reset empties the queue, ends any message, clears
// the message id and sets the payload size to 1024; cfg_we_i writes the size.
module datagram_fragmenter_trailer_unit #(
  parameter int unsigned TRAILER_FIELD_BYTES = dft_pkg::TRAILER_FIELD_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH         = dft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dft_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // data_byte[7:0], message_length[39:8]
  input  logic                       s_axis_tuser,  // empty_message
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // out_byte
  output logic                       m_axis_tlast,  // fragment_last
  output logic                       m_axis_tuser   // message_last
);
  import dft_pkg::*;

  localparam int unsigned CmdW = CTL_W + 24 * TRAILER_FIELD_BYTES;

  logic            push, pop;
  logic [CmdW-1:0] cmd_in, cmd_out;
  q_status_t       q_stat;

  dft_front #(
    .TRAILER_FIELD_BYTES(TRAILER_FIELD_BYTES),
    .CMD_W              (CmdW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata[7:0]),
    .message_length_i(s_axis_tdata[39:8]),
    .empty_message_i (s_axis_tuser),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  dft_queue #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(cmd_in),
    .pop_i (pop),
    .data_o(cmd_out),
    .stat_o(q_stat)
  );

  dft_back #(
    .TRAILER_FIELD_BYTES(TRAILER_FIELD_BYTES),
    .CMD_W              (CmdW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .fragment_last_o(m_axis_tlast),
    .message_last_o (m_axis_tuser)
  );

endmodule
